/* design/tccs_pkg.sv */
`timescale 1ns / 1ps
package tccs_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = ATTR_W + CHAR_W;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL_SETUP,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} in_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              scrolled;
	} out_t;

endpackage

/* design/tccs_ram.sv */
`timescale 1ns / 1ps
module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/text_console_cursor_scroll_unit.sv */
`timescale 1ns / 1ps
// A put without scroll or an unused command finishes in ST_EXEC, a read in ST_READ after
// ST_EXEC, a put that scrolls in an ST_SWEEP after ST_SCROLL_SETUP that blanks the old top
// row, and a clear in an ST_SWEEP over the whole screen (one cell per cycle). One command is
// in flight at a time: a new transfer is taken only in ST_IDLE and with no stalled result held.
// After reset, a pass over every cell blanks the screen RAM; in_stall stays high until it ends.
module text_console_cursor_scroll_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tccs_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tccs_pkg::out_t             out_data,
	input  logic                       cfg_we,
	input  logic [tccs_pkg::ATTR_W-1:0] cfg_wdata
);

	localparam int AW = tccs_pkg::ADDR_W;
	localparam int RW = tccs_pkg::ROW_W;
	localparam int CW = tccs_pkg::COL_W;

	tccs_pkg::state_t state_q, state_n;
	tccs_pkg::in_t    cmd_q;
	tccs_pkg::out_t   out_q, res;

	logic                        out_valid_q;
	logic [tccs_pkg::ATTR_W-1:0] attr_q;
	logic [RW-1:0]               top_q, cur_row_q, cur_row_n;
	logic [CW-1:0]               cur_col_q, cur_col_n;
	logic                        scroll_q, rd_ok_q;
	logic [AW-1:0]               sweep_addr_q, sweep_end_q;

	logic          accept, done, put_scroll, put_write, sweep_last;
	logic [RW-1:0] unit_row, cur_prow, rd_prow;
	logic [CW-1:0] unit_col;
	logic [AW-1:0] unit_addr;
	logic [RW:0]   cur_sum, rd_sum, row_inc;
	logic [CW:0]   col_inc;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tccs_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
	logic [tccs_pkg::ATTR_W-1:0] blank_attr;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != tccs_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign sweep_last = (sweep_addr_q == sweep_end_q);

	// logical row to physical row through the ring offset
	assign cur_sum  = {1'b0, top_q} + {1'b0, cur_row_q};
	assign rd_sum   = {1'b0, top_q} + {1'b0, cmd_q.read_row};
	assign cur_prow = (cur_sum >= (RW+1)'(tccs_pkg::ROWS)) ?
		RW'(cur_sum - (RW+1)'(tccs_pkg::ROWS)) : RW'(cur_sum);
	assign rd_prow  = (rd_sum >= (RW+1)'(tccs_pkg::ROWS)) ?
		RW'(rd_sum - (RW+1)'(tccs_pkg::ROWS)) : RW'(rd_sum);

	// shared address unit: physical row times row length plus column
	always_comb begin
		unit_row = top_q;
		unit_col = '0;
		if (state_q == tccs_pkg::ST_EXEC) begin
			if (cmd_q.cmd == tccs_pkg::CMD_READ) begin
				unit_row = rd_prow;
				unit_col = cmd_q.read_col;
			end else begin
				unit_row = cur_prow;
				unit_col = cur_col_q;
			end
		end
	end

	assign unit_addr = AW'(AW'(unit_row) * AW'(tccs_pkg::COLUMNS)) + AW'(unit_col);

	// cursor movement for a put
	assign col_inc = {1'b0, cur_col_q} + (CW+1)'(1);

	always_comb begin
		cur_row_n  = cur_row_q;
		cur_col_n  = cur_col_q;
		put_write  = 1'b0;
		put_scroll = 1'b0;
		row_inc    = {1'b0, cur_row_q};
		if (state_q == tccs_pkg::ST_EXEC && cmd_q.cmd == tccs_pkg::CMD_PUT) begin
			case (cmd_q.char_code)
				tccs_pkg::CH_NEWLINE: begin
					cur_col_n = '0;
					row_inc   = {1'b0, cur_row_q} + (RW+1)'(1);
				end
				tccs_pkg::CH_RETURN: begin
					cur_col_n = '0;
				end
				tccs_pkg::CH_BACKSPACE: begin
					if (cur_col_q != '0) begin
						cur_col_n = cur_col_q - CW'(1);
					end
				end
				default: begin
					put_write = 1'b1;
					if (col_inc >= (CW+1)'(tccs_pkg::COLUMNS)) begin
						cur_col_n = '0;
						row_inc   = {1'b0, cur_row_q} + (RW+1)'(1);
					end else begin
						cur_col_n = CW'(col_inc);
					end
				end
			endcase
			if (row_inc >= (RW+1)'(tccs_pkg::ROWS)) begin
				put_scroll = 1'b1;
				cur_row_n  = RW'(tccs_pkg::ROWS - 1);
			end else begin
				cur_row_n = RW'(row_inc);
			end
		end else if (state_q == tccs_pkg::ST_EXEC && cmd_q.cmd == tccs_pkg::CMD_CLEAR) begin
			cur_row_n = '0;
			cur_col_n = '0;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			tccs_pkg::ST_INIT: begin
				if (sweep_last) begin
					state_n = tccs_pkg::ST_IDLE;
				end
			end
			tccs_pkg::ST_IDLE: begin
				if (accept) begin
					state_n = tccs_pkg::ST_EXEC;
				end
			end
			tccs_pkg::ST_EXEC: begin
				case (cmd_q.cmd)
					tccs_pkg::CMD_PUT:   state_n = put_scroll ? tccs_pkg::ST_SCROLL_SETUP
					                                          : tccs_pkg::ST_IDLE;
					tccs_pkg::CMD_READ:  state_n = tccs_pkg::ST_READ;
					tccs_pkg::CMD_CLEAR: state_n = tccs_pkg::ST_SWEEP;
					default:             state_n = tccs_pkg::ST_IDLE;
				endcase
			end
			tccs_pkg::ST_READ:         state_n = tccs_pkg::ST_IDLE;
			tccs_pkg::ST_SCROLL_SETUP: state_n = tccs_pkg::ST_SWEEP;
			tccs_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					state_n = tccs_pkg::ST_IDLE;
				end
			end
			default: state_n = tccs_pkg::ST_IDLE;
		endcase
	end

	// outputs: RAM write port and result
	assign blank_attr = (state_q == tccs_pkg::ST_INIT) ? tccs_pkg::RESET_ATTR : attr_q;

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = sweep_addr_q;
		ram_wdata  = {blank_attr, tccs_pkg::CH_BLANK};
		done       = 1'b0;
		res        = '0;
		res.cursor_row = cur_row_n;
		res.cursor_col = cur_col_n;
		case (state_q)
			tccs_pkg::ST_INIT: begin
				ram_we = 1'b1;
			end
			tccs_pkg::ST_EXEC: begin
				ram_we    = put_write;
				ram_waddr = unit_addr;
				ram_wdata = {attr_q, cmd_q.char_code};
				done      = (cmd_q.cmd != tccs_pkg::CMD_READ) &&
				            (cmd_q.cmd != tccs_pkg::CMD_CLEAR) && !put_scroll;
			end
			tccs_pkg::ST_READ: begin
				done           = 1'b1;
				res.cell_value = rd_ok_q ? ram_rdata : '0;
			end
			tccs_pkg::ST_SWEEP: begin
				ram_we       = 1'b1;
				done         = sweep_last;
				res.scrolled = scroll_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tccs_pkg::ST_INIT;
			out_valid_q  <= 1'b0;
			attr_q       <= tccs_pkg::RESET_ATTR;
			top_q        <= '0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			scroll_q     <= 1'b0;
			rd_ok_q      <= 1'b0;
			sweep_addr_q <= '0;
			sweep_end_q  <= AW'(tccs_pkg::CELLS - 1);
		end else begin
			state_q   <= state_n;
			cur_row_q <= cur_row_n;
			cur_col_q <= cur_col_n;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == tccs_pkg::ST_EXEC) begin
				scroll_q <= put_scroll;
				rd_ok_q  <= (cmd_q.read_row < RW'(tccs_pkg::ROWS)) &&
				            (cmd_q.read_col < CW'(tccs_pkg::COLUMNS));
				if (cmd_q.cmd == tccs_pkg::CMD_CLEAR) begin
					top_q        <= '0;
					sweep_addr_q <= '0;
					sweep_end_q  <= AW'(tccs_pkg::CELLS - 1);
				end
			end
			if (state_q == tccs_pkg::ST_SCROLL_SETUP) begin
				// blank the old top row and advance the ring offset
				sweep_addr_q <= unit_addr;
				sweep_end_q  <= unit_addr + AW'(tccs_pkg::COLUMNS - 1);
				top_q        <= (top_q == RW'(tccs_pkg::ROWS - 1)) ? '0 : top_q + RW'(1);
			end
			if ((state_q == tccs_pkg::ST_INIT || state_q == tccs_pkg::ST_SWEEP) && !sweep_last) begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data;
		end
		if (done) begin
			out_q <= res;
		end
	end

	tccs_ram #(
		.WIDTH(tccs_pkg::CELL_W),
		.DEPTH(tccs_pkg::CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (unit_addr),
		.rdata (ram_rdata)
	);

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q < RW'(tccs_pkg::ROWS)) && (cur_col_q < CW'(tccs_pkg::COLUMNS)))
		else $error("cursor outside the screen");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q < RW'(tccs_pkg::ROWS))
		else $error("ring offset outside the screen");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr < AW'(tccs_pkg::CELLS)))
		else $error("screen write beyond the last cell");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid_q && out_stall))
		else $error("result overwrites a stalled transfer");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::ST_IDLE) |-> !ram_we)
		else $error("screen write while idle");

endmodule

/* verif/text_console_cursor_scroll_unit_tb.sv */
`timescale 1ns / 1ps
module text_console_cursor_scroll_unit_tb;

	localparam logic [tccs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 100;

	// Mirror of the screen store, cursor and attribute; predicts each command's status.
	class screen_mirror;
		logic [tccs_pkg::CELL_W-1:0] cells [tccs_pkg::CELLS];
		logic [tccs_pkg::ATTR_W-1:0] attr;
		int top;
		int crow;
		int ccol;
		tccs_pkg::out_t expected_status [$];
		int mismatches;
		int n_reads;
		int n_scrolls;
		int n_clears;

		function new();
			mismatches = 0;
			n_reads = 0;
			n_scrolls = 0;
			n_clears = 0;
		endfunction

		function void blank_row(int prow);
			for (int c = 0; c < tccs_pkg::COLUMNS; c++) begin
				cells[prow * tccs_pkg::COLUMNS + c] = {attr, tccs_pkg::CH_BLANK};
			end
		endfunction

		function void wipe();
			for (int r = 0; r < tccs_pkg::ROWS; r++) begin
				blank_row(r);
			end
			top = 0;
			crow = 0;
			ccol = 0;
		endfunction

		function void power_on();
			attr = tccs_pkg::RESET_ATTR;
			wipe();
		endfunction

		function bit put_char(logic [tccs_pkg::CHAR_W-1:0] ch);
			int old_top;
			if (ch == tccs_pkg::CH_NEWLINE) begin
				ccol = 0;
				crow++;
			end else if (ch == tccs_pkg::CH_RETURN) begin
				ccol = 0;
			end else if (ch == tccs_pkg::CH_BACKSPACE) begin
				if (ccol > 0) begin
					ccol--;
				end
			end else begin
				cells[((top + crow) % tccs_pkg::ROWS) * tccs_pkg::COLUMNS + ccol] = {attr, ch};
				ccol++;
				if (ccol >= tccs_pkg::COLUMNS) begin
					ccol = 0;
					crow++;
				end
			end
			if (crow >= tccs_pkg::ROWS) begin
				// scroll: the old top row becomes the new blank bottom row
				old_top = top;
				top = (top + 1) % tccs_pkg::ROWS;
				blank_row(old_top);
				crow = tccs_pkg::ROWS - 1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_command(tccs_pkg::in_t c);
			tccs_pkg::out_t r;
			r = '0;
			case (c.cmd)
				tccs_pkg::CMD_PUT: begin
					r.scrolled = put_char(c.char_code);
					if (r.scrolled) begin
						n_scrolls++;
					end
				end
				tccs_pkg::CMD_READ: begin
					n_reads++;
					if (c.read_row < tccs_pkg::ROWS && c.read_col < tccs_pkg::COLUMNS) begin
						r.cell_value = cells[((top + c.read_row) % tccs_pkg::ROWS)
							* tccs_pkg::COLUMNS + c.read_col];
					end
				end
				tccs_pkg::CMD_CLEAR: begin
					n_clears++;
					wipe();
				end
				default: begin
				end
			endcase
			r.cursor_row = tccs_pkg::ROW_W'(crow);
			r.cursor_col = tccs_pkg::COL_W'(ccol);
			expected_status.push_back(r);
		endfunction

		function void check_result(tccs_pkg::out_t got);
			tccs_pkg::out_t exp;
			if (expected_status.size() == 0) begin
				$error("result with nothing pending: 0x%0h", got);
				mismatches++;
				return;
			end
			exp = expected_status.pop_front();
			if (got.cell_value !== exp.cell_value) begin
				$error("cell_value: expected 0x%04h, got 0x%04h", exp.cell_value, got.cell_value);
				mismatches++;
			end
			if (got.cursor_row !== exp.cursor_row) begin
				$error("cursor_row: expected %0d, got %0d", exp.cursor_row, got.cursor_row);
				mismatches++;
			end
			if (got.cursor_col !== exp.cursor_col) begin
				$error("cursor_col: expected %0d, got %0d", exp.cursor_col, got.cursor_col);
				mismatches++;
			end
			if (got.scrolled !== exp.scrolled) begin
				$error("scrolled: expected %0d, got %0d", exp.scrolled, got.scrolled);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tccs_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tccs_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [tccs_pkg::ATTR_W-1:0] cfg_wdata = '0;

	screen_mirror sb;
	bit calm = 1'b0;
	int sent = 0;
	int settings = 1;
	int cycle_count = 0;

	text_console_cursor_scroll_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 20);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
	end

	function automatic tccs_pkg::in_t put_cmd(logic [tccs_pkg::CHAR_W-1:0] ch);
		tccs_pkg::in_t c;
		c.cmd = tccs_pkg::CMD_PUT;
		c.char_code = ch;
		c.read_row = tccs_pkg::ROW_W'($urandom);
		c.read_col = tccs_pkg::COL_W'($urandom);
		return c;
	endfunction

	function automatic tccs_pkg::in_t read_cmd(int row, int col);
		tccs_pkg::in_t c;
		c.cmd = tccs_pkg::CMD_READ;
		c.char_code = tccs_pkg::CHAR_W'($urandom);
		c.read_row = tccs_pkg::ROW_W'(row);
		c.read_col = tccs_pkg::COL_W'(col);
		return c;
	endfunction

	function automatic tccs_pkg::in_t other_cmd(logic [tccs_pkg::CMD_W-1:0] op);
		tccs_pkg::in_t c;
		c = $bits(tccs_pkg::in_t)'($urandom);
		c.cmd = op;
		return c;
	endfunction

	function automatic logic [tccs_pkg::CHAR_W-1:0] text_byte();
		if ($urandom_range(0, 19) == 0) begin
			return tccs_pkg::CHAR_W'($urandom_range(0, 255));
		end
		return tccs_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E));
	endfunction

	// Present one command and hold it until the transfer happens.
	task automatic issue(tccs_pkg::in_t c);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.take_command(c);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_status.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_attribute(logic [tccs_pkg::ATTR_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.attr = v;
		settings++;
	endtask

	task automatic directed_items();
		issue(read_cmd(0, 0));
		issue(read_cmd(tccs_pkg::ROWS - 1, tccs_pkg::COLUMNS - 1));
		issue(read_cmd(tccs_pkg::ROWS, 0));
		issue(read_cmd(0, tccs_pkg::COLUMNS));
		issue(read_cmd(31, 127));
		issue(other_cmd(CMD_UNUSED));
		// backspace with the cursor already at column 0
		issue(put_cmd(tccs_pkg::CH_BACKSPACE));
		issue(put_cmd(8'h00));
		issue(put_cmd(8'hFF));
		issue(put_cmd(tccs_pkg::CH_BACKSPACE));
		issue(put_cmd(tccs_pkg::CH_RETURN));
		issue(read_cmd(0, 0));
		issue(read_cmd(0, 1));
		issue(put_cmd(tccs_pkg::CH_NEWLINE));
		issue(put_cmd(8'h7E));
		issue(read_cmd(1, 0));
		issue(other_cmd(tccs_pkg::CMD_CLEAR));
		issue(read_cmd(0, 0));
		issue(read_cmd(1, 0));
	endtask

	// Mostly lines of text with newlines, so the cursor reaches the bottom and scrolls.
	task automatic random_session(int quota);
		int target;
		int pick;
		int n;
		int k;
		target = sent + quota;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				n = $urandom_range(0, 60);
				for (int i = 0; i < n; i++) begin
					issue(put_cmd(text_byte()));
				end
				k = $urandom_range(0, 9);
				if (k < 7) begin
					issue(put_cmd(tccs_pkg::CH_NEWLINE));
				end else if (k < 9) begin
					issue(put_cmd(tccs_pkg::CH_RETURN));
				end
			end else if (pick < 60) begin
				// long line: wraps at the last column
				n = $urandom_range(tccs_pkg::COLUMNS, 2 * tccs_pkg::COLUMNS + 10);
				for (int i = 0; i < n; i++) begin
					issue(put_cmd(tccs_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E))));
				end
				issue(put_cmd(tccs_pkg::CH_NEWLINE));
			end else if (pick < 72) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					k = $urandom_range(0, 9);
					if (k < 4) begin
						issue(read_cmd(sb.crow, $urandom_range(0, tccs_pkg::COLUMNS - 1)));
					end else if (k < 8) begin
						issue(read_cmd($urandom_range(0, tccs_pkg::ROWS - 1),
							$urandom_range(0, tccs_pkg::COLUMNS - 1)));
					end else begin
						issue(read_cmd($urandom_range(0, 31), $urandom_range(0, 127)));
					end
				end
			end else if (pick < 80) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					k = $urandom_range(0, 2);
					if (k == 0) begin
						issue(put_cmd(tccs_pkg::CH_BACKSPACE));
					end else if (k == 1) begin
						issue(put_cmd(tccs_pkg::CH_RETURN));
					end else begin
						issue(put_cmd(text_byte()));
					end
				end
			end else if (pick < 88) begin
				n = $urandom_range(1, 30);
				for (int i = 0; i < n; i++) begin
					issue(put_cmd(tccs_pkg::CH_NEWLINE));
				end
			end else if (pick < 90) begin
				issue(other_cmd(tccs_pkg::CMD_CLEAR));
			end else begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 1) == 0) begin
						issue(other_cmd(CMD_UNUSED));
					end else begin
						issue(put_cmd(tccs_pkg::CHAR_W'($urandom_range(0, 255))));
					end
				end
			end
		end
	endtask

	initial begin
		sb = new();
		sb.power_on();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first phase runs with the reset attribute
		directed_items();
		random_session(210);

		set_attribute(8'h00);
		random_session(260);

		set_attribute(8'hFF);
		calm = 1'b1;
		random_session(260);
		calm = 1'b0;

		set_attribute(tccs_pkg::ATTR_W'($urandom_range(1, 254)));
		random_session(260);

		set_attribute(8'h80);
		random_session(250);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands over %0d attribute settings.", sent, settings);
		$display("That took %0d reads, %0d scrolls and %0d screen clears.",
			sb.n_reads, sb.n_scrolls, sb.n_clears);
		if (sb.mismatches == 0 && sb.expected_status.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
